### rtl/core/swm_pkg.sv
// Shared constants and types for the sliding window minimum block.
// No dependencies; used by swm_cell and sliding_window_minimum.
`timescale 1ns / 1ps

package swm_pkg;

	localparam int WINDOW_MAX_DEF   = 64;
	localparam int SAMPLE_WIDTH_DEF = 32;
	localparam int CFG_W            = 7;
	localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(1);

	// Per-cycle command broadcast to every cell of the queue
	typedef struct packed {
		logic step;   // a sample transaction is taken: age, pop, append
		logic clear;  // start of sequence: window is emptied first
		logic shift;  // front entry leaves, everything moves one cell forward
	} swm_ctrl_t;

endpackage

### rtl/core/swm_cell.sv
// One entry of the monotonic queue: value, age and occupancy.
// Depends on swm_pkg (swm_ctrl_t).
`timescale 1ns / 1ps

module swm_cell #(
	parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
	parameter int AGE_W        = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  swm_pkg::swm_ctrl_t      ctrl,
	input  logic [SAMPLE_WIDTH-1:0] sample,
	input  logic                    left_keep,   // cell ahead keeps its entry
	input  logic                    right_valid, // entry of the cell behind
	input  logic [SAMPLE_WIDTH-1:0] right_value,
	input  logic [AGE_W-1:0]        right_age,
	output logic                    keep,
	output logic                    valid_q,
	output logic [SAMPLE_WIDTH-1:0] value_q,
	output logic [AGE_W-1:0]        age_q
);

	logic                    sh_valid;
	logic [SAMPLE_WIDTH-1:0] sh_value;
	logic [AGE_W-1:0]        sh_age;
	logic                    take_sample;
	logic                    en;

	always_comb begin
		sh_valid = ctrl.shift ? right_valid : valid_q;
		sh_value = ctrl.shift ? right_value : value_q;
		sh_age   = ctrl.shift ? right_age   : age_q;
		if (ctrl.clear) begin
			sh_valid = 1'b0;
		end
	end

	// entries not below the new sample are popped from the back
	assign keep = sh_valid && (!ctrl.step || ($signed(sh_value) < $signed(sample)));
	assign take_sample = ctrl.step && !keep && left_keep;
	assign en = ctrl.step || ctrl.shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else if (en) begin
			if (keep) begin
				valid_q <= 1'b1;
				age_q   <= ctrl.step ? sh_age + AGE_W'(1) : sh_age;
			end else if (take_sample) begin
				valid_q <= 1'b1;
				age_q   <= '0;
			end else begin
				valid_q <= 1'b0;
				age_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q <= take_sample ? sample : sh_value;
		end
	end

endmodule

### rtl/core/sliding_window_minimum.sv
// Sliding window minimum: top level with the cell chain and output register.
// Depends on swm_pkg and swm_cell.
`timescale 1ns / 1ps
//
// Input channel s_*: one transaction per sample; tuser set clears the window
// before the sample is handled. Output channel m_*: one transaction per
// sample, carrying the minimum of the preceding window_length samples, or
// zero with tuser set when no earlier sample is held.
// Configuration channel cfg_*: writes window_length (0 acts as 1, values
// above WINDOW_MAX act as WINDOW_MAX); always ready, write only when idle.
// Result is registered: it appears in the cycle after the input transaction.
// Throughput: one sample per cycle unless the receiver stalls or a front entry
// is being retired; every cell compares with the new sample in parallel.
// After window_length is lowered, the first sample waits until each front
// entry that has grown too old is retired; those are retired one per cycle.
// Reset empties the window and sets window_length to 1. When the receiver
// stalls, the result register holds and s_tready drops until it is taken.
//

module sliding_window_minimum #(
	parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,  // sample
	input  logic                                  s_tuser,  // start_of_sequence
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_tdata,  // window_min
	output logic                                  m_tuser,  // window_empty
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [swm_pkg::CFG_W-1:0]             cfg_data  // window_length
);

	localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int AGE_W  = $clog2(WINDOW_MAX + 1);
	localparam int CMP_W  = (AGE_W > swm_pkg::CFG_W) ? AGE_W : swm_pkg::CFG_W;

	logic [AGE_W-1:0]        len_q;
	logic [CMP_W-1:0]        cfg_ext;
	logic [AGE_W-1:0]        len_next;

	logic                    cvl [WINDOW_MAX+1];
	logic [SAMPLE_WIDTH-1:0] cv  [WINDOW_MAX+1];
	logic [AGE_W-1:0]        ca  [WINDOW_MAX+1];
	logic                    keep [WINDOW_MAX];

	swm_pkg::swm_ctrl_t      ctrl;
	logic [SAMPLE_WIDTH-1:0] sample;
	logic                    trim;
	logic                    accept;
	logic                    drop;
	logic                    empty;
	logic [SAMPLE_WIDTH-1:0] min_q;

	// effective length register, clamped at write time
	assign cfg_ready = 1'b1;
	assign cfg_ext   = CMP_W'(cfg_data);

	always_comb begin
		if (cfg_ext == '0) begin
			len_next = AGE_W'(1);
		end else if (cfg_ext > CMP_W'(WINDOW_MAX)) begin
			len_next = AGE_W'(WINDOW_MAX);
		end else begin
			len_next = cfg_ext[AGE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= AGE_W'(swm_pkg::LEN_RESET);
		end else if (cfg_valid && cfg_ready) begin
			len_q <= len_next;
		end
	end

	// front entry too old for the current length is retired before new samples
	assign trim     = cvl[0] && (ca[0] >= len_q);
	assign s_tready = !trim && (!m_tvalid || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign sample   = s_tdata[SAMPLE_WIDTH-1:0];
	// front expires now when it could not be reported on the next sample
	assign drop     = accept && !s_tuser && cvl[0] &&
	                  (({1'b0, ca[0]} + (AGE_W+1)'(1)) >= {1'b0, len_q});
	assign empty    = s_tuser || !cvl[0];

	always_comb begin
		ctrl.step  = accept;
		ctrl.clear = accept && s_tuser;
		ctrl.shift = trim || drop;
	end

	assign cvl[WINDOW_MAX] = 1'b0;
	assign cv[WINDOW_MAX]  = '0;
	assign ca[WINDOW_MAX]  = '0;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic left_keep;
		if (i == 0) begin : g_front
			assign left_keep = 1'b1;
		end else begin : g_rest
			assign left_keep = keep[i-1];
		end
		swm_cell #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH),
			.AGE_W       (AGE_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.sample     (sample),
			.left_keep  (left_keep),
			.right_valid(cvl[i+1]),
			.right_value(cv[i+1]),
			.right_age  (ca[i+1]),
			.keep       (keep[i]),
			.valid_q    (cvl[i]),
			.value_q    (cv[i]),
			.age_q      (ca[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (accept) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			min_q   <= empty ? '0 : cv[0];
			m_tuser <= empty;
		end
	end

	assign m_tdata = DATA_W'(min_q);

	a_front_filled : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> cvl[0])
		else $error("window empty after a sample transaction");

	a_result_flag : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid && (m_tuser == $past(s_tuser || !cvl[0])))
		else $error("result flag does not match window occupancy");

	a_front_age : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ca[0] < $past(len_q))
		else $error("front entry older than window length after step");

	a_trim_age : assert property (@(posedge clk) disable iff (!arst_n)
		trim |=> !cvl[0] || (ca[0] < $past(ca[0])))
		else $error("ages do not fall along the queue");

endmodule
